>>> sv/rc4_pkg.sv
package rc4_pkg;

   localparam int unsigned BYTE_W          = 8;
   localparam int unsigned PERM_DEPTH      = 256;
   localparam int unsigned PERM_AW         = 8;
   localparam int unsigned KEY_MAX_DEFAULT = 256;

   localparam logic REQ_KEY  = 1'b0;
   localparam logic REQ_DATA = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PASS,
      ST_FILL,
      ST_KS_RD,
      ST_KS_J,
      ST_KS_WK,
      ST_KS_WJ,
      ST_PR_J,
      ST_PR_WI,
      ST_PR_WJ
   } rc4_state_type;

endpackage

>>> sv/rc4_keystream_cipher.sv
// Keyed data byte: taken in idle, then states PR_J, PR_WI and PR_WJ; the result is registered
// in PR_WJ once the output is free. The single read and single write port of the permutation
// memory order the steps (read, read, swap write with keystream read, swap write); no new beat
// is taken until the last byte is through. Data before keying: returned unchanged via ST_PASS.
// Key byte: stored. Last key byte: fill, then KS_RD, KS_J, KS_WK, KS_WJ per entry, then idle.
// Reset clears control state only; permutation and key memories are left as they are.
module rc4_keystream_cipher
   import rc4_pkg::*;
#(
   parameter int unsigned KEY_MAX_BYTES = KEY_MAX_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,   // byte_value
   input  logic              req_tuser,   // req_type
   input  logic              req_tlast,   // last
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [BYTE_W-1:0] rsp_tdata,   // out_byte
   output logic              rsp_tuser    // not_keyed
);

   localparam int unsigned KEY_AW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
   localparam int unsigned KCW    = $clog2(KEY_MAX_BYTES + 1);
   localparam logic [KCW-1:0] KEY_MAX = KCW'(KEY_MAX_BYTES);
   localparam logic [PERM_AW-1:0] K_LAST = PERM_AW'(PERM_DEPTH - 1);

   rc4_state_type state_ff, state_in;

   logic [BYTE_W-1:0] perm_mem [PERM_DEPTH];
   logic [BYTE_W-1:0] key_mem  [KEY_MAX_BYTES];

   logic               perm_we, perm_re, key_we, key_re;
   logic [PERM_AW-1:0] perm_wa, perm_ra;
   logic [BYTE_W-1:0]  perm_wd, perm_rd_ff, key_rd_ff;
   logic [KEY_AW-1:0]  key_wa, key_ra;

   logic [KCW-1:0]     key_count_ff, key_count_in;
   logic [KCW-1:0]     key_len_ff, key_len_in;
   logic [KEY_AW-1:0]  kidx_ff, kidx_in;
   logic [PERM_AW-1:0] k_ff, k_in;
   logic [PERM_AW-1:0] idx_i_ff, idx_i_in, idx_j_ff, idx_j_in;
   logic               keyed_ff, keyed_in;
   logic [BYTE_W-1:0]  data_ff, data_in;
   logic [BYTE_W-1:0]  si_ff, si_in, sj_ff, sj_in;
   logic               hit_i_ff, hit_i_in, hit_j_ff, hit_j_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic               rsp_nk_ff, rsp_nk_in;

   logic               req_take, out_free;
   logic [KCW-1:0]     key_count_next;
   logic [PERM_AW-1:0] j_step, t_addr;
   logic [BYTE_W-1:0]  ks_byte;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_nk_ff;

   assign key_count_next = (key_count_ff < KEY_MAX) ? key_count_ff + 1'b1 : key_count_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_tuser == REQ_KEY) begin
                  if (req_tlast) state_in = ST_FILL;
               end else begin
                  state_in = keyed_ff ? ST_PR_J : ST_PASS;
               end
            end
         end
         ST_PASS:  if (out_free) state_in = ST_IDLE;
         ST_FILL:  if (k_ff == K_LAST) state_in = ST_KS_RD;
         ST_KS_RD: state_in = ST_KS_J;
         ST_KS_J:  state_in = ST_KS_WK;
         ST_KS_WK: state_in = ST_KS_WJ;
         ST_KS_WJ: state_in = (k_ff == K_LAST) ? ST_IDLE : ST_KS_RD;
         ST_PR_J:  state_in = ST_PR_WI;
         ST_PR_WI: state_in = ST_PR_WJ;
         ST_PR_WJ: if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      perm_we      = 1'b0;
      perm_re      = 1'b0;
      perm_wa      = k_ff;
      perm_ra      = k_ff;
      perm_wd      = perm_rd_ff;
      key_we       = 1'b0;
      key_re       = 1'b0;
      key_wa       = key_count_ff[KEY_AW-1:0];
      key_ra       = kidx_ff;
      key_count_in = key_count_ff;
      key_len_in   = key_len_ff;
      kidx_in      = kidx_ff;
      k_in         = k_ff;
      idx_i_in     = idx_i_ff;
      idx_j_in     = idx_j_ff;
      keyed_in     = keyed_ff;
      data_in      = data_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      hit_i_in     = hit_i_ff;
      hit_j_in     = hit_j_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_nk_in    = rsp_nk_ff;
      j_step       = idx_j_ff + perm_rd_ff;
      t_addr       = si_ff + perm_rd_ff;
      ks_byte      = hit_j_ff ? si_ff : (hit_i_ff ? sj_ff : perm_rd_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_tuser == REQ_KEY) begin
                  key_we       = (key_count_ff < KEY_MAX);
                  key_count_in = key_count_next;
                  if (req_tlast) begin
                     key_len_in   = key_count_next;
                     key_count_in = '0;
                     k_in         = '0;
                  end
               end else begin
                  data_in = req_tdata;
                  if (keyed_ff) begin
                     perm_re  = 1'b1;
                     perm_ra  = idx_i_ff + 1'b1;
                     idx_i_in = idx_i_ff + 1'b1;
                  end
               end
            end
         end
         ST_PASS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = data_ff;
               rsp_nk_in    = 1'b1;
            end
         end
         ST_FILL: begin
            perm_we  = 1'b1;
            perm_wd  = k_ff;
            k_in     = k_ff + 1'b1;
            idx_j_in = '0;
            kidx_in  = '0;
         end
         ST_KS_RD: begin
            perm_re = 1'b1;
            key_re  = 1'b1;
         end
         ST_KS_J: begin
            j_step   = idx_j_ff + perm_rd_ff + key_rd_ff;
            idx_j_in = j_step;
            perm_re  = 1'b1;
            perm_ra  = j_step;
            si_in    = perm_rd_ff;
         end
         ST_KS_WK: begin
            perm_we = 1'b1;
         end
         ST_KS_WJ: begin
            perm_we = 1'b1;
            perm_wa = idx_j_ff;
            perm_wd = si_ff;
            k_in    = k_ff + 1'b1;
            kidx_in = ((KCW'(kidx_ff) + 1'b1) == key_len_ff) ? '0 : kidx_ff + 1'b1;
            if (k_ff == K_LAST) begin
               keyed_in = 1'b1;
               idx_i_in = '0;
               idx_j_in = '0;
            end
         end
         ST_PR_J: begin
            si_in    = perm_rd_ff;
            idx_j_in = j_step;
            perm_re  = 1'b1;
            perm_ra  = j_step;
         end
         ST_PR_WI: begin
            perm_we  = 1'b1;
            perm_wa  = idx_i_ff;
            sj_in    = perm_rd_ff;
            perm_re  = 1'b1;
            perm_ra  = t_addr;
            hit_i_in = (t_addr == idx_i_ff);
            hit_j_in = (t_addr == idx_j_ff);
         end
         ST_PR_WJ: begin
            perm_we = 1'b1;
            perm_wa = idx_j_ff;
            perm_wd = si_ff;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = data_ff ^ ks_byte;
               rsp_nk_in    = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (perm_we) perm_mem[perm_wa] <= perm_wd;
      if (perm_re) perm_rd_ff <= perm_mem[perm_ra];
   end

   always_ff @(posedge clock) begin
      if (key_we) key_mem[key_wa] <= req_tdata;
      if (key_re) key_rd_ff <= key_mem[key_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_count_ff <= '0;
         idx_i_ff     <= '0;
         idx_j_ff     <= '0;
         keyed_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_count_ff <= key_count_in;
         idx_i_ff     <= idx_i_in;
         idx_j_ff     <= idx_j_in;
         keyed_ff     <= keyed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_len_ff  <= key_len_in;
      kidx_ff     <= kidx_in;
      k_ff        <= k_in;
      data_ff     <= data_in;
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      hit_i_ff    <= hit_i_in;
      hit_j_ff    <= hit_j_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_nk_ff   <= rsp_nk_in;
   end

   a_keyed_sticks: assert property (@(posedge clock) disable iff (reset)
      keyed_ff |=> keyed_ff)
      else $error("keyed flag dropped");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      key_count_ff <= KEY_MAX)
      else $error("key count beyond key store");

   a_prga_keyed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PR_J || state_ff == ST_PR_WI || state_ff == ST_PR_WJ) |-> keyed_ff)
      else $error("keystream step without key schedule");

   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !perm_we)
      else $error("permutation written while idle");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top
   import rc4_pkg::*;
();

   localparam int unsigned RANDOM_ITEMS = 1000;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned DRAIN_CYCLES = 32;
   localparam int unsigned DIRECTED_N   = 25;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              not_keyed;
   } cipher_out_type;

   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] val;
      logic              fin;
      logic              typed;
      logic [BYTE_W-1:0] exp_byte;
      logic              exp_nk;
   } stim_row_type;

   logic              clock;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [BYTE_W-1:0] req_tdata  = '0;
   logic              req_tuser  = REQ_KEY;
   logic              req_tlast  = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [BYTE_W-1:0] rsp_tdata;
   logic              rsp_tuser;

   rc4_keystream_cipher dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // byte_value
      .req_tuser  (req_tuser),    // req_type
      .req_tlast  (req_tlast),    // last
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // out_byte
      .rsp_tuser  (rsp_tuser)     // not_keyed
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // local copy of the cipher state
   logic [BYTE_W-1:0] sbox      [PERM_DEPTH];
   logic [BYTE_W-1:0] key_bytes [PERM_DEPTH];
   int unsigned       key_len;
   logic [BYTE_W-1:0] idx_i;
   logic [BYTE_W-1:0] idx_j;
   bit                is_keyed;

   cipher_out_type pending_bytes [$];
   cipher_out_type predicted;
   stim_row_type   cur_row;
   int unsigned    error_count   = 0;
   int unsigned    cycle_count   = 0;
   int unsigned    send_gap_pct  = 7;
   int unsigned    recv_gap_pct  = 65;

   function automatic void clear_cipher();
      key_len  = 0;
      idx_i    = '0;
      idx_j    = '0;
      is_keyed = 1'b0;
   endfunction

   function automatic void schedule_key();
      logic [BYTE_W-1:0] j;
      logic [BYTE_W-1:0] t;
      j = '0;
      for (int k = 0; k < PERM_DEPTH; k++) sbox[k] = k[BYTE_W-1:0];
      for (int k = 0; k < PERM_DEPTH; k++) begin
         j       = j + sbox[k] + key_bytes[k % key_len];
         t       = sbox[k];
         sbox[k] = sbox[j];
         sbox[j] = t;
      end
      idx_i    = '0;
      idx_j    = '0;
      is_keyed = 1'b1;
      key_len  = 0;
   endfunction

   // returns 1 when the beat yields a result
   function automatic bit rc4_advance(input logic kind, input logic [BYTE_W-1:0] val,
                                      input logic fin, output cipher_out_type res);
      logic [BYTE_W-1:0] t;
      res = '0;
      if (kind == REQ_KEY) begin
         if (key_len < PERM_DEPTH) begin
            key_bytes[key_len] = val;
            key_len++;
         end
         if (fin) schedule_key();
         return 1'b0;
      end
      if (!is_keyed) begin
         res.out_byte  = val;
         res.not_keyed = 1'b1;
         return 1'b1;
      end
      idx_i       = idx_i + 8'd1;
      idx_j       = idx_j + sbox[idx_i];
      t           = sbox[idx_i];
      sbox[idx_i] = sbox[idx_j];
      sbox[idx_j] = t;
      res.out_byte  = val ^ sbox[BYTE_W'(sbox[idx_i] + sbox[idx_j])];
      res.not_keyed = 1'b0;
      return 1'b1;
   endfunction

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_gap_pct);
   end

   always @(posedge clock) begin
      cipher_out_type head;
      cipher_out_type typed_out;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_bytes.size() == 0) begin
               $display("%0t: unexpected result beat byte=%h not_keyed=%b",
                        $realtime, rsp_tdata, rsp_tuser);
               error_count++;
            end else begin
               head = pending_bytes.pop_front();
               if (rsp_tdata !== head.out_byte) begin
                  $display("%0t: out_byte expected %h actual %h",
                           $realtime, head.out_byte, rsp_tdata);
                  error_count++;
               end
               if (rsp_tuser !== head.not_keyed) begin
                  $display("%0t: not_keyed expected %b actual %b",
                           $realtime, head.not_keyed, rsp_tuser);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (rc4_advance(req_tuser, req_tdata, req_tlast, predicted)) begin
               if (cur_row.typed) begin
                  typed_out.out_byte  = cur_row.exp_byte;
                  typed_out.not_keyed = cur_row.exp_nk;
                  pending_bytes.push_back(typed_out);
               end else begin
                  pending_bytes.push_back(predicted);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("rc4_keystream_cipher regression: fail");
         $finish;
      end
   end

   // tready only moves at the rising edge, so its value at the falling edge holds for the next one
   task automatic send_beat(input stim_row_type row);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      cur_row = row;
      req_tvalid <= 1'b1;
      req_tuser  <= row.kind;
      req_tdata  <= row.val;
      req_tlast  <= row.fin;
      while (!req_tready) @(negedge clock);
      @(negedge clock);
   endtask

   function automatic stim_row_type plain_row(input logic kind, input logic [BYTE_W-1:0] val,
                                              input logic fin);
      stim_row_type r;
      r.kind     = kind;
      r.val      = val;
      r.fin      = fin;
      r.typed    = 1'b0;
      r.exp_byte = '0;
      r.exp_nk   = 1'b0;
      return r;
   endfunction

   initial begin
      stim_row_type directed_rows [DIRECTED_N];
      stim_row_type row;
      int unsigned  sent;
      int unsigned  sess;
      int unsigned  klen;
      int unsigned  dlen;
      int unsigned  pick;

      directed_rows = '{
         // data before any key: passes through flagged
         '{REQ_DATA, 8'h00, 1'b0, 1'b1, 8'h00, 1'b1},
         '{REQ_DATA, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1},
         '{REQ_DATA, 8'hA5, 1'b0, 1'b1, 8'hA5, 1'b1},
         // one-byte zero key
         '{REQ_KEY,  8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
         '{REQ_DATA, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
         '{REQ_DATA, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
         '{REQ_DATA, 8'h5A, 1'b1, 1'b0, 8'h00, 1'b0},
         // next key part loaded, old keystream still in use
         '{REQ_KEY,  8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
         '{REQ_KEY,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
         '{REQ_DATA, 8'h3C, 1'b0, 1'b0, 8'h00, 1'b0},
         '{REQ_KEY,  8'h80, 1'b1, 1'b0, 8'h00, 1'b0},
         '{REQ_DATA, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
         '{REQ_DATA, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
         // key "Key", text "Plaintext"
         '{REQ_KEY,  8'h4B, 1'b0, 1'b0, 8'h00, 1'b0},
         '{REQ_KEY,  8'h65, 1'b0, 1'b0, 8'h00, 1'b0},
         '{REQ_KEY,  8'h79, 1'b1, 1'b0, 8'h00, 1'b0},
         '{REQ_DATA, 8'h50, 1'b0, 1'b0, 8'h00, 1'b0},
         '{REQ_DATA, 8'h6C, 1'b0, 1'b0, 8'h00, 1'b0},
         '{REQ_DATA, 8'h61, 1'b0, 1'b0, 8'h00, 1'b0},
         '{REQ_DATA, 8'h69, 1'b0, 1'b0, 8'h00, 1'b0},
         '{REQ_DATA, 8'h6E, 1'b0, 1'b0, 8'h00, 1'b0},
         '{REQ_DATA, 8'h74, 1'b0, 1'b0, 8'h00, 1'b0},
         '{REQ_DATA, 8'h65, 1'b0, 1'b0, 8'h00, 1'b0},
         '{REQ_DATA, 8'h78, 1'b0, 1'b0, 8'h00, 1'b0},
         '{REQ_DATA, 8'h74, 1'b0, 1'b0, 8'h00, 1'b0}
      };

      clear_cipher();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[n]) send_beat(directed_rows[n]);

      sent = 0;
      sess = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent < RANDOM_ITEMS / 3) begin
            send_gap_pct = 7;
            recv_gap_pct = 65;
         end else if (sent < 2 * RANDOM_ITEMS / 3) begin
            send_gap_pct = 65;
            recv_gap_pct = 7;
         end else begin
            send_gap_pct = 0;
            recv_gap_pct = 0;
         end

         // first two keys overflow and fill the key store exactly
         pick = $urandom_range(99);
         if (sess == 0)      klen = 300;
         else if (sess == 1) klen = PERM_DEPTH;
         else if (pick < 80) klen = $urandom_range(16, 1);
         else if (pick < 95) klen = $urandom_range(255, 17);
         else                klen = $urandom_range(300, 256);
         sess++;

         for (int b = 0; b < klen; b++) begin
            row = plain_row(REQ_KEY, BYTE_W'($urandom_range(255)), b == klen - 1);
            send_beat(row);
            sent++;
            if (b != klen - 1 && $urandom_range(99) < 4) begin
               row = plain_row(REQ_DATA, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
               send_beat(row);
               sent++;
            end
         end

         dlen = $urandom_range(40, 4);
         for (int d = 0; d < dlen; d++) begin
            row = plain_row(REQ_DATA, BYTE_W'($urandom_range(255)), $urandom_range(9) == 0);
            send_beat(row);
            sent++;
         end
      end

      req_tvalid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("rc4_keystream_cipher regression: pass");
      end else begin
         $display("rc4_keystream_cipher regression: fail");
      end
      $finish;
   end

endmodule
